FILE: hdl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the slot pool allocator: controller states,
// request modes, opcodes and reply status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

   localparam int ADDR_W     = 64;
   localparam int SLOT_FLD_W = 6;
   localparam int CSLOT_W    = 7;
   localparam int STATUS_W   = 2;

   localparam logic [ADDR_W-1:0] BASE_RESET = 64'd4096;

   localparam logic OPCODE_ALLOC   = 1'b0;
   localparam logic OPCODE_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAIL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_OFFS,
      ST_SUM,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      MODE_REUSE,
      MODE_SCAN,
      MODE_RELEASE,
      MODE_IGNORE,
      MODE_FULL
   } mode_type;

endpackage

`default_nettype wire

FILE: hdl/spa_ram.sv
// ----------------------------------------------------------------------------
// spa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ram #(
   parameter  int WIDTH = 1,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/slot_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_top
// First-fit slot allocator over a bitmap held in a one-bit-wide RAM, with a
// mapped flag and a count of used slots kept in flip-flops.
// ----------------------------------------------------------------------------
// A release, or an allocate that reuses the client's slot, runs through the
// read, offset, sum and finish states; an ignored release or a full pool goes
// straight to finish; a first-fit allocate scans from slot zero to the lowest
// free slot, then runs through offset, sum and finish. Throughput: one request
// at a time, with the bitmap scanned one slot per cycle; busy falls as the
// reply strobe rises, so a new request may start in the reply cycle. Reset
// clears the bitmap with busy high. The reply side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_allocator_top #(
   parameter int SLOT_COUNT = 64,
   parameter int SLOT_BYTES = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_opcode,
   input  wire logic signed [spa_pkg::CSLOT_W-1:0]   req_client_slot,
   input  wire logic        [spa_pkg::ADDR_W-1:0]    req_client_addr,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic        [spa_pkg::ADDR_W-1:0]    csr_wr_data,
   // reply channel
   output logic                                      rsp_valid,
   output logic             [spa_pkg::STATUS_W-1:0]  rsp_status,
   output logic             [spa_pkg::SLOT_FLD_W-1:0] rsp_granted_slot,
   output logic             [spa_pkg::ADDR_W-1:0]    rsp_granted_addr,
   output logic                                      rsp_pool_unmapped
);

   // Slot index and used-count widths follow the pool size; the slot offset width follows both pool size and slot size.
   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int BW = $clog2(SLOT_BYTES + 1);
   localparam int OW = IW + BW;

   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(SLOT_COUNT);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   spa_pkg::state_type state_ff, state_in;
   spa_pkg::mode_type  mode_ff, mode_in;

   logic [spa_pkg::ADDR_W-1:0] base_ff;
   logic                       mapped_ff, mapped_in;
   logic [CW-1:0]              used_count_ff, used_count_in;
   logic [IW-1:0]              clr_addr_ff;

   // Request payload captured at start.
   logic [spa_pkg::ADDR_W-1:0] caddr_ff;
   logic [IW-1:0]              target_ff;
   logic                       used_ff;

   // First-fit scan pipeline: the address in flight and the index whose bit
   // is on the RAM read data this cycle.
   logic [IW-1:0]              scan_addr_ff;
   logic [IW-1:0]              scan_idx_ff;
   logic                       scan_vld_ff;

   // Slot address arithmetic, one register per step.
   logic [OW-1:0]              offset_ff;
   logic [spa_pkg::ADDR_W-1:0] addr_ff;

   // Reply registers.
   logic                         rsp_valid_ff;
   logic [spa_pkg::STATUS_W-1:0] rsp_status_ff,   rsp_status_in;
   logic [spa_pkg::SLOT_FLD_W-1:0] rsp_slot_ff,   rsp_slot_in;
   logic [spa_pkg::ADDR_W-1:0]   rsp_addr_ff,     rsp_addr_in;
   logic                         rsp_unmapped_ff, rsp_unmapped_in;

   // ------------------------------------------------------------------------
   // Bitmap RAM. Every access is sequenced by the controller: the write of a
   // request happens in its last cycle, and the next read is issued no
   // earlier than the following cycle, so no forwarding path is needed.
   // ------------------------------------------------------------------------
   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   logic [0:0]    ram_wr_data;
   logic [IW-1:0] ram_rd_addr;
   logic [0:0]    ram_rd_data;

   spa_ram #(
      .WIDTH (1),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Request decode. A client slot counts only when it is non-negative and
   // below the pool size. The bitmap is always all zero while the pool is
   // unmapped (unmapping only happens once the last slot is freed, and an
   // unmapped pool sees nothing but releases), so mapping needs no clear.
   // ------------------------------------------------------------------------
   logic          slot_in_range;
   logic [IW-1:0] slot_idx_in;
   logic          accept;

   assign slot_in_range = !req_client_slot[spa_pkg::CSLOT_W-1] &&
                          (32'(req_client_slot[spa_pkg::CSLOT_W-2:0]) < 32'(SLOT_COUNT));
   assign slot_idx_in   = IW'(req_client_slot[spa_pkg::CSLOT_W-2:0]);
   assign accept        = start && (state_ff == spa_pkg::ST_IDLE);

   always_comb begin
      if (req_opcode == spa_pkg::OPCODE_RELEASE) begin
         mode_in = slot_in_range ? spa_pkg::MODE_RELEASE : spa_pkg::MODE_IGNORE;
      end else if (slot_in_range && mapped_ff) begin
         mode_in = spa_pkg::MODE_REUSE;
      end else if (mapped_ff && (used_count_ff == FULL_CNT)) begin
         mode_in = spa_pkg::MODE_FULL;
      end else begin
         mode_in = spa_pkg::MODE_SCAN;
      end
   end

   // The scan has found a free slot when valid read data shows a clear bit.
   logic scan_hit;
   assign scan_hit = scan_vld_ff && (ram_rd_data == 1'b0);

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spa_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = spa_pkg::ST_IDLE;
            end
         end
         spa_pkg::ST_IDLE: begin
            if (start) begin
               case (mode_in)
                  spa_pkg::MODE_REUSE,
                  spa_pkg::MODE_RELEASE: state_in = spa_pkg::ST_READ;
                  spa_pkg::MODE_SCAN:    state_in = spa_pkg::ST_SCAN;
                  default:               state_in = spa_pkg::ST_FINISH;
               endcase
            end
         end
         spa_pkg::ST_READ: state_in = spa_pkg::ST_OFFS;
         spa_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = spa_pkg::ST_OFFS;
            end
         end
         spa_pkg::ST_OFFS:   state_in = spa_pkg::ST_SUM;
         spa_pkg::ST_SUM:    state_in = spa_pkg::ST_FINISH;
         spa_pkg::ST_FINISH: state_in = spa_pkg::ST_IDLE;
         default:            state_in = spa_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Finish decision: ownership check, status, bitmap write-back, count and
   // mapped flag updates. A slot whose address wraps to zero is never owned
   // and can never be granted.
   // ------------------------------------------------------------------------
   logic       owned;
   logic       fin_wr_en;
   logic [0:0] fin_wr_data;

   assign owned = (addr_ff != '0) && (addr_ff == caddr_ff);

   always_comb begin
      fin_wr_en       = 1'b0;
      fin_wr_data     = 1'b0;
      used_count_in   = used_count_ff;
      mapped_in       = mapped_ff;
      rsp_status_in   = spa_pkg::STATUS_FAIL;
      rsp_slot_in     = '0;
      rsp_addr_in     = '0;
      rsp_unmapped_in = 1'b0;
      case (mode_ff)
         spa_pkg::MODE_REUSE,
         spa_pkg::MODE_SCAN: begin
            if (!(used_ff && !owned) && (addr_ff != '0)) begin
               fin_wr_en     = 1'b1;
               fin_wr_data   = 1'b1;
               used_count_in = used_count_ff + CW'(!used_ff);
               rsp_status_in = spa_pkg::STATUS_DONE;
               rsp_slot_in   = spa_pkg::SLOT_FLD_W'(target_ff);
               rsp_addr_in   = addr_ff;
            end
         end
         spa_pkg::MODE_RELEASE: begin
            if (!(mapped_ff && used_ff && !owned)) begin
               fin_wr_en     = 1'b1;
               used_count_in = used_count_ff - CW'(used_ff);
               rsp_status_in = spa_pkg::STATUS_DONE;
               if (mapped_ff && (used_count_in == '0)) begin
                  mapped_in       = 1'b0;
                  rsp_unmapped_in = 1'b1;
               end
            end
         end
         spa_pkg::MODE_IGNORE: rsp_status_in = spa_pkg::STATUS_IGNORED;
         default:              rsp_status_in = spa_pkg::STATUS_FAIL;
      endcase
   end

   // ------------------------------------------------------------------------
   // Controller outputs: busy and the RAM ports.
   // ------------------------------------------------------------------------
   always_comb begin
      busy        = (state_ff != spa_pkg::ST_IDLE);
      ram_wr_en   = 1'b0;
      ram_wr_addr = target_ff;
      ram_wr_data = 1'b0;
      ram_rd_addr = target_ff;
      case (state_ff)
         spa_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
         end
         spa_pkg::ST_IDLE:   ram_rd_addr = slot_idx_in;
         spa_pkg::ST_SCAN:   ram_rd_addr = scan_addr_ff;
         spa_pkg::ST_FINISH: begin
            ram_wr_en   = fin_wr_en;
            ram_wr_data = fin_wr_data;
         end
         default: ram_rd_addr = target_ff;
      endcase
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spa_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         base_ff       <= spa_pkg::BASE_RESET;
         mapped_ff     <= 1'b0;
         used_count_ff <= '0;
         scan_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == spa_pkg::ST_FINISH);
         if (state_ff == spa_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + IW'(1);
         end
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         // A first-fit allocate maps the pool as it starts.
         if (accept && (mode_in == spa_pkg::MODE_SCAN)) begin
            mapped_ff <= 1'b1;
         end else if (state_ff == spa_pkg::ST_FINISH) begin
            mapped_ff <= mapped_in;
         end
         if (state_ff == spa_pkg::ST_FINISH) begin
            used_count_ff <= used_count_in;
         end
         scan_vld_ff <= (state_ff == spa_pkg::ST_SCAN) && !scan_hit;
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff      <= mode_in;
         caddr_ff     <= req_client_addr;
         target_ff    <= slot_idx_in;
         scan_addr_ff <= '0;
      end
      if (state_ff == spa_pkg::ST_READ) begin
         used_ff <= ram_rd_data[0];
      end
      if (state_ff == spa_pkg::ST_SCAN) begin
         scan_idx_ff <= scan_addr_ff;
         if (scan_addr_ff != LAST_SLOT) begin
            scan_addr_ff <= scan_addr_ff + IW'(1);
         end
         if (scan_hit) begin
            target_ff <= scan_idx_ff;
            used_ff   <= 1'b0;
         end
      end
      if (state_ff == spa_pkg::ST_OFFS) begin
         offset_ff <= OW'(target_ff) * OW'(SLOT_BYTES);
      end
      if (state_ff == spa_pkg::ST_SUM) begin
         addr_ff <= base_ff + spa_pkg::ADDR_W'(offset_ff);
      end
      if (state_ff == spa_pkg::ST_FINISH) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_slot_ff     <= rsp_slot_in;
         rsp_addr_ff     <= rsp_addr_in;
         rsp_unmapped_ff <= rsp_unmapped_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_slot  = rsp_slot_ff;
   assign rsp_granted_addr  = rsp_addr_ff;
   assign rsp_pool_unmapped = rsp_unmapped_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // Every reply comes from the finish step of a request.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == spa_pkg::ST_FINISH))
      else $error("reply strobe without a finish step");

   // The used count never exceeds the pool size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= FULL_CNT)
      else $error("used slot count above pool size");

   // An unmapped pool holds no used slot; mapping relies on this.
   a_unmapped_empty: assert property (@(posedge clock) disable iff (reset)
      !mapped_ff |-> (used_count_ff == '0))
      else $error("used slots while the pool is unmapped");

   // A reply that reports an unmap leaves the pool unmapped and empty.
   a_unmap_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unmapped_ff) |-> (!mapped_ff && (used_count_ff == '0)))
      else $error("unmap reported but pool still holds slots");

   // A reply that carries a nonzero address always reports a granted request.
   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_addr_ff != '0)) |-> (rsp_status_ff == spa_pkg::STATUS_DONE))
      else $error("address reported on a failed request");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slot pool allocator. A queue-fed driver issues
// allocate and release requests over the start/busy handshake, a shadow
// allocator predicts each reply, and a monitor compares every reply strobe
// against the oldest prediction while the base address is swept through
// several settings.
// ----------------------------------------------------------------------------

module tb;

   localparam int SLOT_COUNT = 64;
   localparam int SLOT_BYTES = 256;

   // One request as the driver presents it on the req_ ports.
   typedef struct packed {
      logic                               opcode;
      logic signed [spa_pkg::CSLOT_W-1:0] slot;
      logic [spa_pkg::ADDR_W-1:0]         addr;
   } request_type;

   // One reply as the block shows it on the rsp_ ports.
   typedef struct packed {
      logic [spa_pkg::STATUS_W-1:0]   status;
      logic [spa_pkg::SLOT_FLD_W-1:0] slot;
      logic [spa_pkg::ADDR_W-1:0]     addr;
      logic                           unmapped;
   } reply_type;

   // All inputs start from known values; reset is held from time zero.
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               req_opcode = spa_pkg::OPCODE_ALLOC;
   logic signed [spa_pkg::CSLOT_W-1:0] req_client_slot = '0;
   logic [spa_pkg::ADDR_W-1:0]         req_client_addr = '0;
   logic                               csr_wr_en = 1'b0;
   logic [spa_pkg::ADDR_W-1:0]         csr_wr_data = '0;

   wire                                busy;
   wire                                rsp_valid;
   wire [spa_pkg::STATUS_W-1:0]        rsp_status;
   wire [spa_pkg::SLOT_FLD_W-1:0]      rsp_granted_slot;
   wire [spa_pkg::ADDR_W-1:0]          rsp_granted_addr;
   wire                                rsp_pool_unmapped;

   // Requests waiting to be driven, and replies predicted for accepted
   // requests but not yet seen on the reply port.
   request_type pending_requests[$];
   reply_type   expected_replies[$];

   // Shadow copy of the allocator state and of its base address register.
   bit [SLOT_COUNT-1:0]        shadow_used = '0;
   bit                         shadow_mapped = 1'b0;
   logic [spa_pkg::ADDR_W-1:0] shadow_base = spa_pkg::BASE_RESET;

   int  error_count = 0;
   // When set, the driver presents requests without any random gaps.
   bit  no_idle = 1'b0;

   slot_pool_allocator_top #(
      .SLOT_COUNT(SLOT_COUNT),
      .SLOT_BYTES(SLOT_BYTES)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_client_slot  (req_client_slot),
      .req_client_addr  (req_client_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_granted_addr (rsp_granted_addr),
      .rsp_pool_unmapped(rsp_pool_unmapped)
   );

   always #4 clock = ~clock;

   // Address of a slot for a given base; the sum wraps modulo 2^64.
   function automatic logic [spa_pkg::ADDR_W-1:0] slot_addr(
      input logic [spa_pkg::ADDR_W-1:0] base, input int s);
      return base + spa_pkg::ADDR_W'(s * SLOT_BYTES);
   endfunction

   function automatic logic [spa_pkg::ADDR_W-1:0] random_addr();
      return {$urandom, $urandom};
   endfunction

   // Applies one request to the shadow allocator and returns the reply the
   // block must give for it. A slot whose address wraps to zero can never be
   // granted or owned, and every field but status is zero on a failure.
   function automatic reply_type predict_reply(input request_type rq);
      reply_type                  r;
      int                         s;
      int                         i;
      bit                         in_range;
      bit                         found;
      logic [spa_pkg::ADDR_W-1:0] a;
      r.status   = spa_pkg::STATUS_FAIL;
      r.slot     = '0;
      r.addr     = '0;
      r.unmapped = 1'b0;
      s = int'($signed(rq.slot));
      in_range = (s >= 0) && (s < SLOT_COUNT);
      if (rq.opcode == spa_pkg::OPCODE_ALLOC) begin
         if (in_range && shadow_mapped) begin
            // Reuse the client's slot if it is free or already owned.
            a = slot_addr(shadow_base, s);
            if (a != 0 && (!shadow_used[s] || a == rq.addr)) begin
               shadow_used[s] = 1'b1;
               r.status = spa_pkg::STATUS_DONE;
               r.slot   = spa_pkg::SLOT_FLD_W'(s);
               r.addr   = a;
            end
         end else begin
            if (!shadow_mapped) begin
               shadow_mapped = 1'b1;
               shadow_used   = '0;
            end
            // First fit; a wrapped address at the lowest free slot fails.
            found = 1'b0;
            for (i = 0; i < SLOT_COUNT && !found; i++) begin
               if (!shadow_used[i]) begin
                  found = 1'b1;
                  a = slot_addr(shadow_base, i);
                  if (a != 0) begin
                     shadow_used[i] = 1'b1;
                     r.status = spa_pkg::STATUS_DONE;
                     r.slot   = spa_pkg::SLOT_FLD_W'(i);
                     r.addr   = a;
                  end
               end
            end
         end
      end else begin
         if (!in_range) begin
            r.status = spa_pkg::STATUS_IGNORED;
         end else begin
            a = slot_addr(shadow_base, s);
            // Only a slot in use by someone else is protected, and only
            // while the pool is mapped.
            if (!(shadow_mapped && shadow_used[s] && !(a != 0 && a == rq.addr))) begin
               shadow_used[s] = 1'b0;
               r.status = spa_pkg::STATUS_DONE;
               if (shadow_mapped && shadow_used == '0) begin
                  shadow_mapped = 1'b0;
                  r.unmapped    = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   // Driver. A request is taken at an edge where start is high and busy is
   // low; its reply is predicted at that same edge. A request that is not yet
   // taken is held unchanged. The next request may be presented while the
   // block is still busy, so it can be taken in the reply cycle.
   always @(posedge clock) begin : driver
      request_type rq;
      bit          taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            rq.opcode = req_opcode;
            rq.slot   = req_client_slot;
            rq.addr   = req_client_addr;
            expected_replies.push_back(predict_reply(rq));
         end
         if (start && !taken) begin
            // Keep the current request on the ports until busy drops.
         end else if (pending_requests.size() != 0 &&
                      (no_idle || $urandom_range(99) >= 10)) begin
            rq = pending_requests.pop_front();
            req_opcode      <= rq.opcode;
            req_client_slot <= rq.slot;
            req_client_addr <= rq.addr;
            start           <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. Every reply strobe is matched against the oldest prediction.
   always @(posedge clock) begin : monitor
      reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            $error("reply with no request outstanding: status %0h", rsp_status);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0h, got %0h", want.status, rsp_status);
               error_count++;
            end
            if (rsp_granted_slot !== want.slot) begin
               $error("granted_slot: expected %0h, got %0h", want.slot, rsp_granted_slot);
               error_count++;
            end
            if (rsp_granted_addr !== want.addr) begin
               $error("granted_addr: expected %0h, got %0h", want.addr, rsp_granted_addr);
               error_count++;
            end
            if (rsp_pool_unmapped !== want.unmapped) begin
               $error("pool_unmapped: expected %0h, got %0h", want.unmapped,
                      rsp_pool_unmapped);
               error_count++;
            end
         end
      end
   end

   task automatic push_request(input logic op, input int s,
                               input logic [spa_pkg::ADDR_W-1:0] a);
      request_type rq;
      rq.opcode = op;
      rq.slot   = spa_pkg::CSLOT_W'(s);
      rq.addr   = a;
      pending_requests.push_back(rq);
   endtask

   // Waits, at falling edges to stay clear of the driver and monitor, until
   // every queued request has been taken and every reply has come back.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_replies.size() != 0)
         @(negedge clock);
   endtask

   // Only called with nothing in flight, so the shadow base can follow the
   // register at once.
   task automatic write_base(input logic [spa_pkg::ADDR_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      shadow_base = v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic for one base address. Most of it is shaped like real use:
   // bursts of first-fit allocates (some long enough to fill the pool), sweeps
   // of releases with the owners' addresses (which drain and unmap the pool),
   // and clients reusing or releasing their own slot. The rest is noise with
   // wrong owners and arbitrary field values.
   task automatic add_random_requests(input int count,
                                      input logic [spa_pkg::ADDR_W-1:0] base);
      int                         made;
      int                         pick;
      int                         len;
      int                         s;
      int                         i;
      logic [spa_pkg::ADDR_W-1:0] a;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            len = ($urandom_range(99) < 15) ? $urandom_range(64, 70) : $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
               // Clients holding no slot: mostly slot -1, some other negative slot values.
               s = ($urandom_range(3) == 0) ? -int'($urandom_range(1, 64)) : -1;
               push_request(spa_pkg::OPCODE_ALLOC, s,
                            ($urandom_range(1) == 0) ? '0 : random_addr());
            end
            made += len;
         end else if (pick < 50) begin
            len = ($urandom_range(99) < 25) ? SLOT_COUNT : $urandom_range(1, 12);
            for (i = 0; i < len; i++)
               push_request(spa_pkg::OPCODE_RELEASE, i, slot_addr(base, i));
            made += len;
         end else if (pick < 88) begin
            s = ($urandom_range(3) == 0) ? $urandom_range(0, SLOT_COUNT - 1)
                                         : $urandom_range(0, 15);
            case ($urandom_range(4))
               0:       a = '0;
               1:       a = random_addr();
               2:       a = slot_addr(base, $urandom_range(0, SLOT_COUNT - 1));
               default: a = slot_addr(base, s);
            endcase
            push_request((pick < 70) ? spa_pkg::OPCODE_ALLOC : spa_pkg::OPCODE_RELEASE, s, a);
            made++;
         end else begin
            case ($urandom_range(3))
               0:       a = '0;
               1:       a = '1;
               default: a = random_addr();
            endcase
            push_request(1'($urandom_range(1)), $urandom_range(0, 127), a);
            made++;
         end
      end
   endtask

   // Run sequence: reset, a directed pass at the reset base, then random
   // traffic under a series of base addresses. The bases include both ends
   // of the legal range and values where one slot address wraps to zero.
   initial begin : stimulus
      logic [spa_pkg::ADDR_W-1:0] bases[7];
      int                         p;
      logic [spa_pkg::ADDR_W-1:0] b;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // The block clears its bitmap after reset with busy high.
      @(negedge clock);
      while (busy) @(negedge clock);

      b = spa_pkg::BASE_RESET;
      // Releases with no slot are ignored; a release while unmapped just
      // clears the bit.
      push_request(spa_pkg::OPCODE_RELEASE, -1, '0);
      push_request(spa_pkg::OPCODE_RELEASE, -64, '1);
      push_request(spa_pkg::OPCODE_RELEASE, 5, '0);
      // First allocate maps the pool, then reuse of a free slot, a refused
      // reuse by a non-owner, and reuse by the owner.
      push_request(spa_pkg::OPCODE_ALLOC, -1, '0);
      push_request(spa_pkg::OPCODE_ALLOC, 5, '1);
      push_request(spa_pkg::OPCODE_ALLOC, 5, '0);
      push_request(spa_pkg::OPCODE_ALLOC, 5, slot_addr(b, 5));
      push_request(spa_pkg::OPCODE_ALLOC, 63, slot_addr(b, 63));
      push_request(spa_pkg::OPCODE_ALLOC, -1, '0);
      // A non-owner release is rejected; owner releases drain the pool and
      // the last one unmaps it.
      push_request(spa_pkg::OPCODE_RELEASE, 0, '1);
      push_request(spa_pkg::OPCODE_RELEASE, 0, slot_addr(b, 0));
      push_request(spa_pkg::OPCODE_RELEASE, 1, slot_addr(b, 1));
      push_request(spa_pkg::OPCODE_RELEASE, 5, slot_addr(b, 5));
      push_request(spa_pkg::OPCODE_RELEASE, 63, slot_addr(b, 63));
      // A held slot does not count while unmapped: first fit from slot zero.
      push_request(spa_pkg::OPCODE_ALLOC, 63, '0);
      push_request(spa_pkg::OPCODE_ALLOC, 0, slot_addr(b, 0));
      push_request(spa_pkg::OPCODE_RELEASE, 0, slot_addr(b, 0));
      push_request(spa_pkg::OPCODE_RELEASE, 0, slot_addr(b, 0));
      wait_drained();

      bases[0] = 64'd1;
      bases[1] = '1;
      bases[2] = 64'd0 - 64'(3 * SLOT_BYTES);
      bases[3] = random_addr();
      bases[4] = 64'd0 - 64'((SLOT_COUNT - 1) * SLOT_BYTES);
      bases[5] = {32'd0, $urandom} << 8;
      bases[6] = spa_pkg::BASE_RESET;
      if (bases[3] == 0) bases[3] = 64'd1;
      if (bases[5] == 0) bases[5] = 64'd256;

      for (p = 0; p < 7; p++) begin
         write_base(bases[p]);
         // One phase runs without any gaps on the request side.
         no_idle = (p == 2);
         add_random_requests(262, bases[p]);
         wait_drained();
      end
      no_idle = 1'b0;

      // Allow for any stray reply after the last one, then report.
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Safety net in case the block stops replying.
   initial begin : watchdog
      #6000000;
      $display("tb: errors");
      $finish;
   end

endmodule
